FILE: rtl/palindrome_substring_lister_assert.svh
// Assertion macros used by the checker file.
`ifndef PALINDROME_SUBSTRING_LISTER_ASSERT_SVH
`define PALINDROME_SUBSTRING_LISTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("palindrome lister check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("palindrome lister check failed");

`endif

FILE: rtl/psl_pkg.sv
package psl_pkg;

	localparam int MAX_LEN = 512;
	localparam int MIN_PAL = 2;

	// address of one stored byte
	localparam int ADDR_W = $clog2(MAX_LEN);
	// text length, 0 .. MAX_LEN
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	// search length cursor, 2 .. MAX_LEN + 1
	localparam int CUR_W = $clog2(MAX_LEN + 2);
	// start + length sums
	localparam int SUM_W = CUR_W + 1;
	localparam int CHAR_W = 8;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_NEXT = 1'b1
	} psl_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_CMP,
		ST_EMIT
	} psl_state_t;

endpackage

FILE: rtl/psl_ram.sv
module psl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/palindrome_substring_lister.sv
// Channel | Handshake         | Payload                                         | Direction
// in      | in_valid/in_ready | opcode, char_in, last_char                      | into block
// out     | out_valid/out_ready | pal_start, pal_end, pal_length, done_res, truncated | out of block
//
// A load transaction gives no result; loads stream at one per cycle while no next is in flight.
// A next transaction is accepted, then steps through the candidate starts and lengths, reads
// each character pair from the RAM and then compares it, closes a candidate whose pairs all
// match, and fills the output register; the cost is data dependent and bounded by the scan
// of the remaining list.
// Reset (arst_n low) empties the string, opens it for loading and clears out_valid.
// A finished result waits in the output register; loads are still taken meanwhile, and a
// following next transaction stalls only at its own result until that register frees.
module palindrome_substring_lister (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [psl_pkg::CHAR_W-1:0]  char_in,
	input  logic                        last_char,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [psl_pkg::ADDR_W-1:0]  pal_start,
	output logic [psl_pkg::ADDR_W-1:0]  pal_end,
	output logic [psl_pkg::LEN_W-1:0]   pal_length,
	output logic                        done_res,
	output logic                        truncated
);

	import psl_pkg::*;

	psl_state_t state_q, state_d;

	// string bookkeeping
	logic [LEN_W-1:0]  text_len_q, text_len_d;
	logic              closed_q, closed_d;
	logic              ovf_q, ovf_d;

	// search cursor: current length and next candidate start
	logic [CUR_W-1:0]  cur_len_q, cur_len_d;
	logic [ADDR_W-1:0] cur_start_q, cur_start_d;

	// pair pointers walking inward over one candidate
	logic [ADDR_W-1:0] lo_q, lo_d;
	logic [ADDR_W-1:0] hi_q, hi_d;

	// pending result of the running search
	logic [ADDR_W-1:0] res_start_q, res_start_d;
	logic [ADDR_W-1:0] res_end_q, res_end_d;
	logic [LEN_W-1:0]  res_len_q, res_len_d;
	logic              res_done_q, res_done_d;

	// output register
	logic              out_valid_q, out_valid_d;
	logic [ADDR_W-1:0] out_start_q, out_start_d;
	logic [ADDR_W-1:0] out_end_q, out_end_d;
	logic [LEN_W-1:0]  out_len_q, out_len_d;
	logic              out_done_q, out_done_d;
	logic              out_trunc_q, out_trunc_d;

	// text RAM write side
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CHAR_W-1:0] ch_lo, ch_hi;

	logic              in_fire;
	logic [LEN_W-1:0]  eff_len;
	logic              eff_ovf;
	logic [SUM_W-1:0]  span;
	logic [SUM_W-1:0]  span_m1;

	// Two copies of the text, written together, so both ends of a pair are read in the same cycle.
	psl_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_LEN)
	) u_ram_lo (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (char_in),
		.raddr (lo_q),
		.rdata (ch_lo)
	);

	psl_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_LEN)
	) u_ram_hi (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (char_in),
		.raddr (hi_q),
		.rdata (ch_hi)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// a load after a closed string starts over at an empty text
	assign eff_len = closed_q ? '0 : text_len_q;
	assign eff_ovf = closed_q ? 1'b0 : ovf_q;

	assign span    = SUM_W'(cur_start_q) + SUM_W'(cur_len_q);
	assign span_m1 = span - SUM_W'(1);

	assign ram_waddr = eff_len[ADDR_W-1:0];

	always_comb begin
		state_d     = state_q;
		text_len_d  = text_len_q;
		closed_d    = closed_q;
		ovf_d       = ovf_q;
		cur_len_d   = cur_len_q;
		cur_start_d = cur_start_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		res_start_d = res_start_q;
		res_end_d   = res_end_q;
		res_len_d   = res_len_q;
		res_done_d  = res_done_q;
		out_start_d = out_start_q;
		out_end_d   = out_end_q;
		out_len_d   = out_len_q;
		out_done_d  = out_done_q;
		out_trunc_d = out_trunc_q;
		ram_we      = 1'b0;

		// drop the output once the consumer takes it
		out_valid_d = out_valid_q && !out_ready;

		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (opcode == OP_LOAD) begin
						if (eff_len < LEN_W'(MAX_LEN)) begin
							ram_we     = 1'b1;
							text_len_d = eff_len + LEN_W'(1);
							ovf_d      = eff_ovf;
						end else begin
							text_len_d = eff_len;
							ovf_d      = 1'b1;
						end
						closed_d    = last_char;
						cur_len_d   = CUR_W'(MIN_PAL);
						cur_start_d = '0;
					end else if (!closed_q) begin
						// string still open: answer done, leave the cursor alone
						res_start_d = '0;
						res_end_d   = '0;
						res_len_d   = '0;
						res_done_d  = 1'b1;
						state_d     = ST_EMIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end

			ST_SCAN: begin
				if (SUM_W'(cur_len_q) > SUM_W'(text_len_q)) begin
					// list exhausted
					res_start_d = '0;
					res_end_d   = '0;
					res_len_d   = '0;
					res_done_d  = 1'b1;
					state_d     = ST_EMIT;
				end else if (span > SUM_W'(text_len_q)) begin
					// no start left at this length: advance to the next length
					cur_len_d   = cur_len_q + CUR_W'(1);
					cur_start_d = '0;
				end else begin
					lo_d        = cur_start_q;
					hi_d        = span_m1[ADDR_W-1:0];
					res_start_d = cur_start_q;
					res_end_d   = span_m1[ADDR_W-1:0];
					res_len_d   = LEN_W'(cur_len_q);
					res_done_d  = 1'b0;
					cur_start_d = cur_start_q + ADDR_W'(1);
					state_d     = ST_READ;
				end
			end

			ST_READ: begin
				// pointers met or crossed: every pair matched
				if (lo_q >= hi_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CMP;
				end
			end

			ST_CMP: begin
				if (ch_lo != ch_hi) begin
					state_d = ST_SCAN;
				end else begin
					lo_d    = lo_q + ADDR_W'(1);
					hi_d    = hi_q - ADDR_W'(1);
					state_d = ST_READ;
				end
			end

			ST_EMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_start_d = res_start_q;
					out_end_d   = res_end_q;
					out_len_d   = res_len_q;
					out_done_d  = res_done_q;
					out_trunc_d = ovf_q;
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			text_len_q  <= '0;
			closed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			cur_len_q   <= CUR_W'(MIN_PAL);
			cur_start_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			text_len_q  <= text_len_d;
			closed_q    <= closed_d;
			ovf_q       <= ovf_d;
			cur_len_q   <= cur_len_d;
			cur_start_q <= cur_start_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		res_start_q <= res_start_d;
		res_end_q   <= res_end_d;
		res_len_q   <= res_len_d;
		res_done_q  <= res_done_d;
		out_start_q <= out_start_d;
		out_end_q   <= out_end_d;
		out_len_q   <= out_len_d;
		out_done_q  <= out_done_d;
		out_trunc_q <= out_trunc_d;
	end

	assign out_valid  = out_valid_q;
	assign pal_start  = out_start_q;
	assign pal_end    = out_end_q;
	assign pal_length = out_len_q;
	assign done_res   = out_done_q;
	assign truncated  = out_trunc_q;

endmodule

FILE: rtl/psl_chk.sv
`include "palindrome_substring_lister_assert.svh"

module psl_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        opcode,
	input logic [psl_pkg::CHAR_W-1:0]  char_in,
	input logic                        last_char,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [psl_pkg::ADDR_W-1:0]  pal_start,
	input logic [psl_pkg::ADDR_W-1:0]  pal_end,
	input logic [psl_pkg::LEN_W-1:0]   pal_length,
	input logic                        done_res,
	input logic                        truncated
);

	import psl_pkg::*;

	logic load_fire;
	logic [LEN_W:0] span_len;

	assign load_fire = in_valid && in_ready && (opcode == OP_LOAD);
	assign span_len  = {2'b00, pal_end} - {2'b00, pal_start} + (LEN_W + 1)'(1);

	// a done result carries no substring
	`PSL_ASSERT_NOW(a_done_zero, clk, arst_n, out_valid && done_res,
		pal_start == '0 && pal_end == '0 && pal_length == '0)

	// a found substring is consistent and at least two long
	`PSL_ASSERT_NOW(a_pal_shape, clk, arst_n, out_valid && !done_res,
		pal_length >= LEN_W'(MIN_PAL) && span_len == {1'b0, pal_length})

	// a load never stalls the input for the next cycle
	`PSL_ASSERT_NEXT(a_load_one_cycle, clk, arst_n, load_fire, in_ready)

	// a stalled result holds
	`PSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pal_start) && $stable(pal_end) && $stable(pal_length)
		&& $stable(done_res) && $stable(truncated))

endmodule

bind palindrome_substring_lister psl_chk u_psl_chk (.*);

FILE: bench/testbench.sv
module testbench;
	import psl_pkg::*;

	// One result transaction, field for field as it leaves the block.
	typedef struct packed {
		logic [ADDR_W-1:0] start_idx;
		logic [ADDR_W-1:0] end_idx;
		logic [LEN_W-1:0]  length;
		logic              done;
		logic              trunc;
	} pal_res_t;

	// One row of the opening script. A row with typed set carries its answer
	// inline; every other row is answered by the listing predictor.
	typedef struct packed {
		psl_op_t     op;
		logic [7:0]  ch;
		logic        lst;
		logic        typed;
		pal_res_t    want;
	} script_row_t;

	localparam pal_res_t NONE_LEFT = '{9'd0, 9'd0, 10'd0, 1'b1, 1'b0};

	// Opening script: next before anything is closed, next in the middle of
	// a load, the byte extremes, a list that runs out and keeps saying done,
	// a load after a closed string, a one-byte string, and a reopened string.
	localparam script_row_t OPENING [24] = '{
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, NONE_LEFT},
		'{OP_LOAD, 8'h00, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, NONE_LEFT},
		'{OP_LOAD, 8'hFF, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'h00, 1'b1, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, '{9'd0, 9'd2, 10'd3, 1'b0, 1'b0}},
		'{OP_NEXT, 8'hFF, 1'b1, 1'b1, NONE_LEFT},
		'{OP_NEXT, 8'hFF, 1'b1, 1'b1, NONE_LEFT},
		'{OP_LOAD, 8'h55, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'h55, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'hAA, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'h55, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'h55, 1'b1, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b0, '0},
		'{OP_LOAD, 8'h7E, 1'b1, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, NONE_LEFT},
		'{OP_LOAD, 8'h80, 1'b0, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, NONE_LEFT},
		'{OP_LOAD, 8'h80, 1'b1, 1'b0, '0},
		'{OP_NEXT, 8'h00, 1'b0, 1'b1, '{9'd0, 9'd1, 10'd2, 1'b0, 1'b0}}
	};

	localparam int unsigned ITEM_TARGET = 1300;
	localparam int unsigned HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              opcode = OP_LOAD;
	logic [CHAR_W-1:0] char_in = '0;
	logic              last_char = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ADDR_W-1:0] pal_start;
	logic [ADDR_W-1:0] pal_end;
	logic [LEN_W-1:0]  pal_length;
	logic              done_res;
	logic              truncated;

	always #5 clk = ~clk;

	palindrome_substring_lister u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.char_in    (char_in),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pal_start  (pal_start),
		.pal_end    (pal_end),
		.pal_length (pal_length),
		.done_res   (done_res),
		.truncated  (truncated)
	);

	// Shadow copy of the block's string and search cursor.
	logic [CHAR_W-1:0] text_mem [MAX_LEN];
	int unsigned       text_len = 0;
	int unsigned       scan_len = MIN_PAL;
	int unsigned       scan_start = 0;
	logic              overflow = 1'b0;
	logic              closed = 1'b0;

	pal_res_t    expected_pals [$];
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned sent = 0;
	int unsigned burst_left = 0;
	logic        last_done = 1'b0;

	// Compare the two ends of a candidate pairwise, walking inward.
	function automatic bit mirrored(input int unsigned s, input int unsigned len);
		int unsigned k;
		for (k = 0; k < len / 2; k++)
			if (text_mem[ADDR_W'(s + k)] != text_mem[ADDR_W'(s + len - 1 - k)])
				return 1'b0;
		return 1'b1;
	endfunction

	// Advance the shadow state by one input transaction; return 1 when the
	// transaction produces a result, which is left in r.
	function automatic bit predict_listing(input psl_op_t op, input logic [7:0] ch,
			input logic lst, output pal_res_t r);
		int unsigned s;
		r = '0;
		if (op == OP_LOAD) begin
			// a load after the closing byte starts a fresh string
			if (closed) begin
				text_len = 0;
				overflow = 1'b0;
				closed = 1'b0;
			end
			// drop bytes past capacity, but remember that we did
			if (text_len < MAX_LEN) begin
				text_mem[ADDR_W'(text_len)] = ch;
				text_len++;
			end else begin
				overflow = 1'b1;
			end
			if (lst)
				closed = 1'b1;
			scan_len = MIN_PAL;
			scan_start = 0;
			return 1'b0;
		end
		r.trunc = overflow;
		r.done = 1'b1;
		// an open string lists nothing and leaves the cursor alone
		if (!closed)
			return 1'b1;
		// shortest lengths first, then left to right within a length
		while (scan_len <= text_len) begin
			while (scan_start + scan_len <= text_len) begin
				s = scan_start;
				scan_start++;
				if (mirrored(s, scan_len)) begin
					r.start_idx = ADDR_W'(s);
					r.end_idx = ADDR_W'(s + scan_len - 1);
					r.length = LEN_W'(scan_len);
					r.done = 1'b0;
					return 1'b1;
				end
			end
			scan_len++;
			scan_start = 0;
		end
		return 1'b1;
	endfunction

	// Offer one transaction and hold it until the block takes it. Acceptance is
	// judged at the falling edge, where valid and ready are settled, and takes
	// effect at the rising edge that follows. Then model the burst gaps.
	task automatic issue(input psl_op_t op, input logic [7:0] ch, input logic lst,
			input logic typed, input pal_res_t typed_want);
		pal_res_t    r;
		logic        taken;
		int unsigned gap;
		opcode <= op;
		char_in <= ch;
		last_char <= lst;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		if (predict_listing(op, ch, lst, r)) begin
			expected_pals.push_back(typed ? typed_want : r);
			last_done = r.done;
		end
		sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic load_char(input logic [7:0] ch, input logic lst);
		issue(OP_LOAD, ch, lst, 1'b0, '0);
	endtask

	task automatic ask_next();
		issue(OP_NEXT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// Stop offering and wait until every outstanding result has come back.
	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_pals.size() != 0);
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Result checker: a result transaction seen at the falling edge is taken at
	// the next rising edge, so check it here against the oldest expectation.
	always @(negedge clk) begin
		pal_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_pals.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, expected none, got %0d..%0d",
					$time, pal_start, pal_end);
			end else begin
				want = expected_pals.pop_front();
				compare_field("pal_start", 16'(want.start_idx), 16'(pal_start));
				compare_field("pal_end", 16'(want.end_idx), 16'(pal_end));
				compare_field("pal_length", 16'(want.length), 16'(pal_length));
				compare_field("done_res", 16'(want.done), 16'(done_res));
				compare_field("truncated", 16'(want.trunc), 16'(truncated));
			end
		end
	end

	// Receiver: switch between randomly chosen stall patterns, and at
	// two points hold ready low for a long stretch so the block backs up.
	initial begin
		int unsigned hold_left;
		int unsigned hold_mark;
		int unsigned span_left;
		int unsigned mode;
		logic [7:0]  stall_pat;
		hold_left = 0;
		hold_mark = 150;
		span_left = 0;
		mode = 0;
		stall_pat = 8'hFF;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (results_seen >= hold_mark) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_mark = (hold_mark < 500) ? hold_mark + 450 : 32'hFFFF_FFFF;
			end else begin
				if (span_left == 0) begin
					mode = $urandom_range(0, 3);
					span_left = $urandom_range(8, 80);
					stall_pat = 8'($urandom_range(1, 255));
				end
				span_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: begin
						out_ready <= stall_pat[0];
						stall_pat = {stall_pat[0], stall_pat[7:1]};
					end
				endcase
			end
		end
	end

	// Stimulus: opening script, then random strings and noise.
	initial begin
		int unsigned  i;
		int unsigned  len;
		int unsigned  alpha;
		int unsigned  cap;
		int unsigned  extra;
		int unsigned  kind;
		int unsigned  next_drain;
		logic         long_done;
		logic [7:0]   letters [4];
		long_done = 1'b0;
		next_drain = 300;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[r])
			issue(OPENING[r].op, OPENING[r].ch, OPENING[r].lst, OPENING[r].typed,
				OPENING[r].want);
		drain_results();

		while (sent < $size(OPENING) + ITEM_TARGET) begin
			if (sent >= next_drain) begin
				drain_results();
				next_drain += 300;
			end
			kind = $urandom_range(0, 99);
			if (!long_done && sent >= 700) begin
				// overflow: fill past capacity from a two-letter alphabet, close
				// on a dropped byte, and ask for a few entries only
				long_done = 1'b1;
				letters[0] = 8'($urandom_range(0, 255));
				letters[1] = letters[0] ^ 8'($urandom_range(1, 255));
				len = MAX_LEN + $urandom_range(1, 3);
				for (i = 0; i < len; i++)
					load_char(letters[2'($urandom_range(0, 1))], i == len - 1);
				repeat (3) ask_next();
			end else if (kind < 75) begin
				// well-formed string, then walk its list, usually to the end
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				case ($urandom_range(0, 3))
					0: alpha = 1;
					1: alpha = 2;
					2: alpha = 3;
					default: alpha = 256;
				endcase
				for (i = 0; i < 4; i++)
					letters[2'(i)] = 8'($urandom_range(0, 255));
				for (i = 0; i < len; i++) begin
					// a next while the string is still open just reports done
					if (i > 0 && $urandom_range(0, 15) == 0)
						ask_next();
					load_char((alpha == 256) ? 8'($urandom_range(0, 255))
						: letters[2'($urandom_range(0, alpha - 1))], i == len - 1);
				end
				cap = $urandom_range(1, 30);
				extra = $urandom_range(0, 2);
				for (i = 0; i < cap; i++) begin
					ask_next();
					if (last_done) begin
						repeat (extra) ask_next();
						break;
					end
				end
			end else if (kind < 88) begin
				// broken: loads that never close, then nexts against them
				len = $urandom_range(1, 5);
				for (i = 0; i < len; i++)
					load_char(8'($urandom_range(0, 255)), 1'b0);
				repeat ($urandom_range(1, 2)) ask_next();
			end else begin
				// noise: any mix of operations and flags
				len = $urandom_range(1, 6);
				for (i = 0; i < len; i++)
					issue($urandom_range(0, 1) ? OP_NEXT : OP_LOAD, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: give up well past the slowest legal run.
	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/psl_pkg.sv
rtl/psl_ram.sv
rtl/palindrome_substring_lister.sv
rtl/psl_chk.sv
bench/testbench.sv
